### hdl/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg
// Types, constants and small lookup functions shared by the calendar minute
// adjust block.
// ----------------------------------------------------------------------------
package cma_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned DELTA_W  = 12;
  // signed minute total, -1439 .. 2878
  localparam int unsigned TOTAL_W  = 13;
  // minute of the day, 0 .. 1439
  localparam int unsigned TOD_W    = 11;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [YEAR_W-1:0]   YEAR_MAX    = 14'd9999;
  localparam logic [MONTH_W-1:0]  MONTH_JAN   = 4'd1;
  localparam logic [MONTH_W-1:0]  MONTH_FEB   = 4'd2;
  localparam logic [MONTH_W-1:0]  MONTH_DEC   = 4'd12;
  localparam logic [DAY_W-1:0]    DAY_FIRST   = 5'd1;
  localparam logic [DAY_W-1:0]    DAY_DEC_END = 5'd31;
  localparam logic [HOUR_W-1:0]   HOUR_MAX    = 5'd23;
  localparam logic [MINUTE_W-1:0] MINUTE_MAX  = 6'd59;
  localparam logic signed [DELTA_W-1:0] DELTA_MAX = 12'sd1439;
  localparam logic signed [DELTA_W-1:0] DELTA_FLOOR = -12'sd1439;
  localparam logic signed [TOTAL_W-1:0] MIN_PER_DAY = 13'sd1440;

  // reciprocal of 60 for minute-of-day values below 1440: hour = (t * 1093) >> 16
  localparam logic [TOD_W-1:0] RECIP60   = 11'd1093;
  localparam int unsigned      RECIP60_SH = 16;
  // multiples of 25 below 10000: low 17 bits of y * 5243 stay below 5243
  localparam logic [12:0] RECIP25     = 13'd5243;
  localparam int unsigned RECIP25_SH  = 17;
  localparam logic [16:0] DIV25_LIMIT = 17'd5243;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // start minute of each hour of the day
  localparam logic [TOD_W-1:0] HOUR_BASE [24] = '{
    11'd0,    11'd60,   11'd120,  11'd180,  11'd240,  11'd300,
    11'd360,  11'd420,  11'd480,  11'd540,  11'd600,  11'd660,
    11'd720,  11'd780,  11'd840,  11'd900,  11'd960,  11'd1020,
    11'd1080, 11'd1140, 11'd1200, 11'd1260, 11'd1320, 11'd1380
  };

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [DELTA_W-1:0]  delta_minutes;
  } cma_in_t;

  // clamped date plus signed minute total
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [TOTAL_W-1:0] total;
    logic               sat;
  } cma_prep_t;

  typedef struct packed {
    logic [YEAR_W-1:0]   new_year;
    logic [MONTH_W-1:0]  new_month;
    logic [DAY_W-1:0]    new_day;
    logic [HOUR_W-1:0]   new_hour;
    logic [MINUTE_W-1:0] new_minute;
    logic                year_saturated;
  } cma_out_t;

  // days in month m (1..12), february follows the leap flag
  function automatic logic [DAY_W-1:0] days_in_month(logic [MONTH_W-1:0] m, logic leap);
    logic [MONTH_W-1:0] idx;
    idx = m - MONTH_JAN;
    if (m == MONTH_FEB && leap) begin
      return 5'd29;
    end
    return MONTH_LEN[idx];
  endfunction

endpackage

### hdl/cma_prep.sv
// ----------------------------------------------------------------------------
// cma_prep
// Clamps the incoming fields to their legal ranges and forms the signed
// minute-of-day total including the offset.
// ----------------------------------------------------------------------------
module cma_prep import cma_pkg::*; (
  input  cma_in_t   in_i,
  output cma_prep_t prep_o
);

  logic [MONTH_W-1:0]  month_c;
  logic [DAY_W-1:0]    day_c;
  logic [HOUR_W-1:0]   hour_c;
  logic [MINUTE_W-1:0] minute_c;
  logic signed [DELTA_W-1:0] delta_s;
  logic signed [DELTA_W-1:0] delta_c;
  logic signed [TOTAL_W-1:0] total_s;

  // range clamps
  always_comb begin
    delta_s = $signed(in_i.delta_minutes);

    if (in_i.month < MONTH_JAN) begin
      month_c = MONTH_JAN;
    end else if (in_i.month > MONTH_DEC) begin
      month_c = MONTH_DEC;
    end else begin
      month_c = in_i.month;
    end

    day_c    = (in_i.day < DAY_FIRST) ? DAY_FIRST : in_i.day;
    hour_c   = (in_i.hour > HOUR_MAX) ? HOUR_MAX : in_i.hour;
    minute_c = (in_i.minute > MINUTE_MAX) ? MINUTE_MAX : in_i.minute;

    if (delta_s < DELTA_FLOOR) begin
      delta_c = DELTA_FLOOR;
    end else if (delta_s > DELTA_MAX) begin
      delta_c = DELTA_MAX;
    end else begin
      delta_c = delta_s;
    end
  end

  // minute of the day plus offset
  always_comb begin
    total_s = $signed({2'b00, HOUR_BASE[hour_c]})
            + $signed({{(TOTAL_W-MINUTE_W){1'b0}}, minute_c})
            + TOTAL_W'(delta_c);
  end

  always_comb begin
    prep_o.sat   = (in_i.year > YEAR_MAX);
    prep_o.year  = prep_o.sat ? YEAR_MAX : in_i.year;
    prep_o.month = month_c;
    prep_o.day   = day_c;
    prep_o.total = total_s;
  end

endmodule

### hdl/cma_calc.sv
// ----------------------------------------------------------------------------
// cma_calc
// Wraps the minute total into one day, splits it into hour and minute and
// moves the date by one day on a borrow or carry.
// ----------------------------------------------------------------------------
module cma_calc import cma_pkg::*; (
  input  cma_prep_t prep_i,
  output cma_out_t  res_o
);

  logic signed [TOTAL_W-1:0] total_s;
  logic signed [TOTAL_W-1:0] tod_s;
  logic                      borrow;
  logic                      carry;
  logic [TOD_W-1:0]          tod;
  logic [2*TOD_W-1:0]        hour_prod;
  logic [HOUR_W-1:0]         hour;
  logic [YEAR_W+12:0]        y25_prod;
  logic                      div25;
  logic                      leap;
  logic [MONTH_W-1:0]        prev_month;
  logic [DAY_W:0]            day_inc;
  logic [DAY_W-1:0]          cur_len;

  // wrap the total into 0 .. 1439
  always_comb begin
    total_s = $signed(prep_i.total);
    borrow  = total_s[TOTAL_W-1];
    carry   = !borrow && (total_s >= MIN_PER_DAY);
    if (borrow) begin
      tod_s = total_s + MIN_PER_DAY;
    end else if (carry) begin
      tod_s = total_s - MIN_PER_DAY;
    end else begin
      tod_s = total_s;
    end
    tod = tod_s[TOD_W-1:0];
  end

  // hour by reciprocal; the minute is taken as the remainder in the date step
  always_comb begin
    hour_prod = tod * RECIP60;
    hour      = hour_prod[RECIP60_SH +: HOUR_W];
  end

  // leap year: divisible by 4, and by 16 when divisible by 25
  always_comb begin
    y25_prod = prep_i.year * RECIP25;
    div25    = (y25_prod[RECIP25_SH-1:0] < DIV25_LIMIT);
    leap     = (prep_i.year[1:0] == 2'b00) && (!div25 || prep_i.year[3:0] == 4'b0000);
  end

  // date step
  always_comb begin
    prev_month = prep_i.month - MONTH_JAN;
    day_inc    = {1'b0, prep_i.day} + 6'd1;
    cur_len    = days_in_month(prep_i.month, leap);

    res_o.new_year       = prep_i.year;
    res_o.new_month      = prep_i.month;
    res_o.new_day        = prep_i.day;
    res_o.year_saturated = prep_i.sat;
    res_o.new_hour       = hour;
    res_o.new_minute     = MINUTE_W'(tod - HOUR_BASE[hour]);

    if (borrow) begin
      if (prep_i.day == DAY_FIRST) begin
        if (prep_i.month == MONTH_JAN) begin
          res_o.new_month = MONTH_DEC;
          res_o.new_day   = DAY_DEC_END;
          if (prep_i.year == '0) begin
            res_o.year_saturated = 1'b1;
          end else begin
            res_o.new_year = prep_i.year - 14'd1;
          end
        end else begin
          res_o.new_month = prev_month;
          res_o.new_day   = days_in_month(prev_month, leap);
        end
      end else begin
        res_o.new_day = prep_i.day - 5'd1;
      end
    end else if (carry) begin
      if (day_inc > {1'b0, cur_len}) begin
        res_o.new_day = DAY_FIRST;
        if (prep_i.month == MONTH_DEC) begin
          res_o.new_month = MONTH_JAN;
          if (prep_i.year == YEAR_MAX) begin
            res_o.year_saturated = 1'b1;
          end else begin
            res_o.new_year = prep_i.year + 14'd1;
          end
        end else begin
          res_o.new_month = prep_i.month + 4'd1;
        end
      end else begin
        res_o.new_day = day_inc[DAY_W-1:0];
      end
    end
  end

endmodule

### hdl/calendar_minute_adjust.sv
// ----------------------------------------------------------------------------
// calendar_minute_adjust
// Path: an accepted word is registered in prep_q, and its result is then
// registered in res_q, which drives m_axis_tdata; a stall holds it in prep_q.
// Throughput: one word per cycle while m_axis_tready is high.
// Reset: rst_ni clears both stage valid flags; payload registers are not reset.
// Adds a signed minute offset below one day to a Gregorian date and time.
// ----------------------------------------------------------------------------
module calendar_minute_adjust import cma_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28],
  // delta_minutes[45:34], zero fill[47:46]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // new_year[13:0], new_month[17:14], new_day[22:18], new_hour[27:23],
  // new_minute[33:28], zero fill[39:34]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // year_saturated[0]
  output logic                   m_axis_tuser
);

  cma_in_t   in_word;
  cma_prep_t prep_d;
  cma_prep_t prep_q;
  cma_out_t  res_d;
  cma_out_t  res_q;
  logic      s1_valid_q;
  logic      out_valid_q;
  logic      s1_ready;
  logic      out_ready;

  // unpack input word
  always_comb begin
    in_word.year          = s_axis_tdata[13:0];
    in_word.month         = s_axis_tdata[17:14];
    in_word.day           = s_axis_tdata[22:18];
    in_word.hour          = s_axis_tdata[27:23];
    in_word.minute        = s_axis_tdata[33:28];
    in_word.delta_minutes = s_axis_tdata[45:34];
  end

  cma_prep u_prep (
    .in_i   (in_word),
    .prep_o (prep_d)
  );

  cma_calc u_calc (
    .prep_i (prep_q),
    .res_o  (res_d)
  );

  // pipeline handshake
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s1_ready      = !s1_valid_q || out_ready;
  assign s_axis_tready = s1_ready;

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s1_ready) begin
      prep_q <= prep_d;
    end
    if (s1_valid_q && out_ready) begin
      res_q <= res_d;
    end
  end

  // pack result word
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, res_q.new_minute, res_q.new_hour, res_q.new_day,
                          res_q.new_month, res_q.new_year};
  assign m_axis_tuser  = res_q.year_saturated;

  // checks
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.new_hour <= HOUR_MAX && res_q.new_minute <= MINUTE_MAX))
    else $error("result time of day out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.new_year <= YEAR_MAX && res_q.new_month >= MONTH_JAN &&
                     res_q.new_month <= MONTH_DEC && res_q.new_day >= DAY_FIRST))
    else $error("result date out of range");

  a_stage_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_ready) |=> out_valid_q)
    else $error("stage word lost on transfer to output register");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled while output register empty");

endmodule

### tb/sv/calendar_minute_adjust_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_minute_adjust_checker
// Watches both stream channels of the minute adjust block. Every accepted
// input word is run through a date arithmetic predictor and the expected
// result is queued. Every accepted output word is compared field by field
// with the oldest queued result. Counts of words and mismatches go to the top.
// ----------------------------------------------------------------------------
module calendar_minute_adjust_checker import cma_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   m_axis_tuser,
  output int                     fail_count_o,
  output int                     words_in_o,
  output int                     words_out_o
);

  cma_out_t pending_dates[$];
  int       mismatches = 0;
  int       seen_in    = 0;
  int       seen_out   = 0;

  // gregorian leap rule: every 400th year, or every 4th that is not a 100th
  function automatic int month_days(int yr, int mon);
    logic leap_year;
    leap_year = (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
    case (mon)
      2:             return leap_year ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // expected date and time after adding the signed minute offset
  function automatic cma_out_t shift_date_time(logic [IN_TDATA_W-1:0] w);
    cma_in_t  f;
    cma_out_t r;
    int       yr, mon, dy, hr, mn, ofs, tod;
    logic     held;
    f.year          = w[13:0];
    f.month         = w[17:14];
    f.day           = w[22:18];
    f.hour          = w[27:23];
    f.minute        = w[33:28];
    f.delta_minutes = w[45:34];
    yr   = int'(f.year);
    mon  = int'(f.month);
    dy   = int'(f.day);
    hr   = int'(f.hour);
    mn   = int'(f.minute);
    ofs  = int'($signed(f.delta_minutes));
    held = 1'b0;
    // bring out-of-range inputs back into range
    if (yr > int'(YEAR_MAX)) begin
      yr   = int'(YEAR_MAX);
      held = 1'b1;
    end
    if (mon < 1) mon = 1;
    if (mon > 12) mon = 12;
    if (dy < 1) dy = 1;
    if (hr > 23) hr = 23;
    if (mn > 59) mn = 59;
    if (ofs < -1439) ofs = -1439;
    if (ofs > 1439) ofs = 1439;
    // minute of the day, then at most one day of borrow or carry
    tod = hr * 60 + mn + ofs;
    if (tod < 0) begin
      tod += 1440;
      dy  -= 1;
      if (dy < 1) begin
        mon -= 1;
        if (mon < 1) begin
          mon = 12;
          yr -= 1;
        end
        dy = month_days(yr, mon);
      end
    end else if (tod >= 1440) begin
      tod -= 1440;
      dy  += 1;
      if (dy > month_days(yr, mon)) begin
        dy   = 1;
        mon += 1;
        if (mon > 12) begin
          mon = 1;
          yr += 1;
        end
      end
    end
    // year saturation at both ends
    if (yr < 0) begin
      yr   = 0;
      held = 1'b1;
    end
    if (yr > int'(YEAR_MAX)) begin
      yr   = int'(YEAR_MAX);
      held = 1'b1;
    end
    r.new_year       = YEAR_W'(yr);
    r.new_month      = MONTH_W'(mon);
    r.new_day        = DAY_W'(dy);
    r.new_hour       = HOUR_W'(tod / 60);
    r.new_minute     = MINUTE_W'(tod % 60);
    r.year_saturated = held;
    return r;
  endfunction

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // sample both channels at the clock edge
  always @(posedge clk_i) begin
    cma_out_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_dates.push_back(shift_date_time(s_axis_tdata));
        seen_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen_out++;
        if (pending_dates.size() == 0) begin
          $display("%0t: result word with no expected word, actual tdata %h tuser %b",
                   $time, m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          want = pending_dates.pop_front();
          compare_field("new_year", 32'(want.new_year), 32'(m_axis_tdata[13:0]));
          compare_field("new_month", 32'(want.new_month), 32'(m_axis_tdata[17:14]));
          compare_field("new_day", 32'(want.new_day), 32'(m_axis_tdata[22:18]));
          compare_field("new_hour", 32'(want.new_hour), 32'(m_axis_tdata[27:23]));
          compare_field("new_minute", 32'(want.new_minute), 32'(m_axis_tdata[33:28]));
          compare_field("zero fill", 32'd0, 32'(m_axis_tdata[OUT_TDATA_W-1:34]));
          compare_field("year_saturated", 32'(want.year_saturated), 32'(m_axis_tuser));
        end
      end
    end
    fail_count_o <= mismatches;
    words_in_o   <= seen_in;
    words_out_o  <= seen_out;
  end

endmodule

### tb/sv/calendar_minute_adjust_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_minute_adjust_tb
// Drives date and time words with signed minute offsets into the minute
// adjust block: a directed set for range ends, leap years and year
// saturation, then random words biased toward month and year boundaries.
// Both channels idle in random bursts; the checker beside the block
// predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module calendar_minute_adjust_tb import cma_pkg::*; ();

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  int fail_count;
  int words_in;
  int words_out;
  bit quiet_tail = 1'b0;
  int gap_odds   = 2;

  calendar_minute_adjust DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  calendar_minute_adjust_checker date_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .words_in_o    (words_in),
    .words_out_o   (words_out)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  // fields packed from the lowest bit up, offset kept to its low 12 bits
  function automatic logic [IN_TDATA_W-1:0] pack_date(int yr, int mon, int dy, int hr,
                                                      int mn, int ofs);
    logic [31:0] ofs_bits;
    ofs_bits = ofs;
    return {2'b00, ofs_bits[DELTA_W-1:0], MINUTE_W'(mn), HOUR_W'(hr), DAY_W'(dy),
            MONTH_W'(mon), YEAR_W'(yr)};
  endfunction

  // random word: a fifth raw bit patterns, the rest in-range fields biased toward edges
  function automatic logic [IN_TDATA_W-1:0] random_date();
    int yr, mon, dy, hr, mn, ofs;
    if ($urandom_range(0, 9) < 2) begin
      return pack_date($urandom_range(0, 16383), $urandom_range(0, 15),
                       $urandom_range(0, 31), $urandom_range(0, 31),
                       $urandom_range(0, 63), $urandom_range(0, 4095));
    end
    case ($urandom_range(0, 13))
      0:       yr = 0;
      1:       yr = 1;
      2:       yr = 4;
      3:       yr = 100;
      4:       yr = 400;
      5:       yr = 1900;
      6:       yr = 2000;
      7:       yr = 2100;
      8:       yr = 9996;
      9:       yr = 9999;
      default: yr = $urandom_range(0, 9999);
    endcase
    mon = $urandom_range(1, 12);
    case ($urandom_range(0, 6))
      0:       dy = 1;
      1:       dy = 28;
      2:       dy = 29;
      3:       dy = 30;
      4:       dy = 31;
      default: dy = $urandom_range(1, 31);
    endcase
    case ($urandom_range(0, 3))
      0: begin
        hr = 0;
        mn = $urandom_range(0, 5);
      end
      1: begin
        hr = 23;
        mn = $urandom_range(54, 59);
      end
      default: begin
        hr = $urandom_range(0, 23);
        mn = $urandom_range(0, 59);
      end
    endcase
    case ($urandom_range(0, 4))
      0:       ofs = -int'($urandom_range(1, 60));
      1:       ofs = int'($urandom_range(1, 60));
      2:       ofs = $urandom_range(0, 1) ? 1439 : -1439;
      default: ofs = int'($urandom_range(0, 2878)) - 1439;
    endcase
    return pack_date(yr, mon, dy, hr, mn, ofs);
  endfunction

  // hold the word until accepted, then maybe idle for a burst
  task automatic send_date(input logic [IN_TDATA_W-1:0] w);
    s_axis_tdata  <= w;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (!quiet_tail && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // output side back-pressure in bursts, with long ready stretches
  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!quiet_tail) begin
        case ($urandom_range(0, 7))
          0: begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk_i);
            m_axis_tready <= 1'b1;
          end
          1: repeat ($urandom_range(30, 120)) @(posedge clk_i);
          default: ;
        endcase
      end
    end
  end

  // reset, stimulus and verdict
  initial begin
    int guard;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: nominal, saturation, leap years, clamped inputs
    send_date(pack_date(2024, 1, 15, 12, 30, 0));
    send_date(pack_date(0, 1, 1, 0, 0, -1));
    send_date(pack_date(9999, 12, 31, 23, 59, 1));
    send_date(pack_date(16383, 6, 15, 10, 10, 5));
    send_date(pack_date(2000, 2, 28, 23, 0, 60));
    send_date(pack_date(1900, 2, 28, 23, 0, 60));
    send_date(pack_date(2023, 2, 28, 23, 59, 1));
    send_date(pack_date(2024, 2, 29, 23, 59, 1));
    send_date(pack_date(2000, 3, 1, 0, 0, -1));
    send_date(pack_date(2100, 3, 1, 0, 0, -1));
    send_date(pack_date(2024, 1, 1, 0, 0, -1439));
    send_date(pack_date(2023, 12, 31, 23, 59, 1439));
    send_date(pack_date(2024, 0, 10, 5, 5, 0));
    send_date(pack_date(2024, 15, 31, 23, 59, 1));
    send_date(pack_date(2024, 5, 0, 0, 0, -1));
    send_date(pack_date(2024, 2, 31, 23, 59, 1));
    send_date(pack_date(2024, 4, 31, 0, 0, -1));
    send_date(pack_date(2024, 7, 10, 31, 63, 0));
    send_date(pack_date(2024, 7, 10, 12, 0, -2048));
    send_date(pack_date(2024, 7, 10, 12, 0, 2047));
    send_date(pack_date(2024, 7, 10, 0, 0, 1439));
    send_date(pack_date(2024, 7, 10, 23, 59, -1439));
    send_date(pack_date(9999, 12, 31, 23, 59, -1));
    send_date(pack_date(0, 1, 1, 0, 1, -1));
    send_date(pack_date(16383, 12, 31, 23, 59, 1));

    // random words, idling rate changes every hundred words
    for (int n = 0; n < 1300; n++) begin
      if (n % 100 == 0) gap_odds = $urandom_range(0, 4);
      if (n == 1150) quiet_tail = 1'b1;
      send_date(random_date());
    end
    s_axis_tvalid <= 1'b0;

    // drain, then keep watching for anything unexpected
    @(posedge clk_i);
    guard = 0;
    while (words_out != words_in && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);

    if (words_out != words_in) begin
      $display("%0t: %0d result words never arrived", $time, words_in - words_out);
    end
    if (fail_count == 0 && words_out == words_in) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### calendar_minute_adjust.f
hdl/cma_pkg.sv
hdl/cma_prep.sv
hdl/cma_calc.sv
hdl/calendar_minute_adjust.sv
tb/sv/calendar_minute_adjust_checker.sv
tb/sv/calendar_minute_adjust_tb.sv
